// ===== rtl/slt_pkg.sv =====
// Package for the sorted list table.
// Holds the operation codes, the sequencer states and the cell control struct.
// No dependencies.
package slt_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int KEY_W     = 32;
    localparam int POS_W     = 6;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic               ins;
        logic               rem;
        logic [KEY_W-1:0]   key;
    } t_cell_ctl;

endpackage

// ===== rtl/sorted_list_table.sv =====
// Top level of the sorted list table: a row of key cells and the sequencer.
// Depends on slt_pkg and slt_cell.
//
// Keeps up to DEPTH signed keys in ascending order in a row of cells. Each item
// (insert, remove, read, clear) is accepted in the idle state and carried out in
// the exec state, in which every cell compares its key with the item's key in
// parallel; an insert or remove shifts the row by one place. A new item is taken
// only in the idle state. A result waits in an output register, and the next item
// is accepted while it waits; the row updates only once that register is free.
module sorted_list_table
    import slt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_mode,
    input  logic signed [KEY_W-1:0] i_key_value,
    input  logic [POS_W-1:0]        i_position,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_success,
    output logic signed [KEY_W-1:0] o_read_value,
    output logic [CNT_OUT_W-1:0]    o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = ($clog2(DEPTH) > POS_W) ? $clog2(DEPTH) : POS_W;

    t_state             r_state, n_state;
    t_op                r_mode;
    logic [KEY_W-1:0]   r_key;
    logic [POS_W-1:0]   r_pos;
    logic [CW-1:0]      r_count, n_count;
    logic               r_out_valid;
    logic               r_success, n_success;
    logic [KEY_W-1:0]   r_read_value, n_read_value;

    logic               w_accept, w_fire, w_found, w_rd_ok;
    logic [KEY_W-1:0]   w_rd_val;
    t_cell_ctl          w_ctl;

    logic [DEPTH-1:0]   w_valid, w_sel, w_lt, w_hit;
    logic [KEY_W-1:0]   w_key [DEPTH];
    logic [KEY_W-1:0]   w_rd  [DEPTH];

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_fire   = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            assign w_valid[g] = (r_count > CW'(g));
            assign w_sel[g]   = (IW'(r_pos) == IW'(g));
            slt_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_valid    (w_valid[g]),
                .i_sel      (w_sel[g]),
                .i_prev_lt  ((g == 0) ? 1'b1 : w_lt[(g == 0) ? 0 : g - 1]),
                .i_prev_key ((g == 0) ? '0 : w_key[(g == 0) ? 0 : g - 1]),
                .i_next_key ((g == DEPTH - 1) ? '0 : w_key[(g == DEPTH - 1) ? g : g + 1]),
                .o_lt       (w_lt[g]),
                .o_hit      (w_hit[g]),
                .o_key      (w_key[g]),
                .o_rd       (w_rd[g])
            );
        end
    endgenerate

    always_comb begin
        w_rd_val = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rd_val = w_rd_val | w_rd[i];
        end
    end

    assign w_found = |w_hit;
    assign w_rd_ok = |(w_sel & w_valid);

    always_comb begin
        w_ctl.key = r_key;
        w_ctl.ins = w_fire && (r_mode == OP_INSERT) && (r_count < CW'(DEPTH));
        w_ctl.rem = w_fire && (r_mode == OP_REMOVE) && w_found;
    end

    always_comb begin
        n_count      = r_count;
        n_success    = 1'b0;
        n_read_value = '0;
        case (r_mode)
            OP_INSERT: begin
                if (r_count < CW'(DEPTH)) begin
                    n_success = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
            OP_REMOVE: begin
                if (w_found) begin
                    n_success = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            OP_READ: begin
                if (w_rd_ok) begin
                    n_success    = 1'b1;
                    n_read_value = w_rd_val;
                end
            end
            OP_CLEAR: begin
                if (r_count != '0) begin
                    n_success = 1'b1;
                    n_count   = '0;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= t_op'(i_mode);
            r_key  <= i_key_value;
            r_pos  <= i_position;
        end
        if (w_fire) begin
            r_success    <= n_success;
            r_read_value <= n_read_value;
        end
    end

    logic [CW-1:0] r_out_count;

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_count <= n_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_success     = r_success;
    assign o_read_value  = r_read_value;
    assign o_entry_count = CNT_OUT_W'(r_out_count);

endmodule

// ===== rtl/slt_cell.sv =====
// One cell of the sorted list table: holds one key, compares it with the
// key of the current item and shifts toward either neighbor.
// Depends on slt_pkg.
module slt_cell
    import slt_pkg::*;
(
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  logic                i_valid,
    input  logic                i_sel,
    input  logic                i_prev_lt,
    input  logic [KEY_W-1:0]    i_prev_key,
    input  logic [KEY_W-1:0]    i_next_key,
    output logic                o_lt,
    output logic                o_hit,
    output logic [KEY_W-1:0]    o_key,
    output logic [KEY_W-1:0]    o_rd
);

    logic [KEY_W-1:0] r_key;

    assign o_key = r_key;
    assign o_lt  = i_valid && ($signed(r_key) < $signed(i_ctl.key));
    assign o_hit = i_valid && !o_lt && i_prev_lt && (r_key == i_ctl.key);
    assign o_rd  = (i_valid && i_sel) ? r_key : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !o_lt) begin
            r_key <= i_prev_lt ? i_ctl.key : i_prev_key;
        end else if (i_ctl.rem && !o_lt) begin
            r_key <= i_next_key;
        end
    end

endmodule
